### hw/rtl/vpz_pkg.sv
// Shared types, codes and arithmetic helpers for the viewport pan and zoom controller.
`timescale 1ns / 1ps
`default_nettype none
package vpz_pkg;

    localparam int unsigned DIV_BITS = 30;
    localparam int unsigned DIV_CNT_W = 5;
    localparam logic [15:0] WINDOW_SCALE_DEFAULT = 16'd4096;
    localparam logic [15:0] DESKTOP_SCALE_DEFAULT = 16'd4096;
    localparam logic [13:0] SIDE_MAX = 14'd16383;

    localparam logic [3:0] CMD_REFRESH   = 4'd0;
    localparam logic [3:0] CMD_UP        = 4'd1;
    localparam logic [3:0] CMD_DOWN      = 4'd2;
    localparam logic [3:0] CMD_LEFT      = 4'd3;
    localparam logic [3:0] CMD_RIGHT     = 4'd4;
    localparam logic [3:0] CMD_ZOOM_IN   = 4'd5;
    localparam logic [3:0] CMD_ZOOM_OUT  = 4'd6;
    localparam logic [3:0] CMD_RST_SCALE = 4'd7;
    localparam logic [3:0] CMD_RST_POS   = 4'd8;
    localparam logic [3:0] CMD_TOGGLE    = 4'd9;
    localparam logic [3:0] CMD_NEW       = 4'd10;

    localparam logic [2:0] REG_SCREEN_W = 3'd0;
    localparam logic [2:0] REG_SCREEN_H = 3'd1;
    localparam logic [2:0] REG_CLIENT_W = 3'd2;
    localparam logic [2:0] REG_CLIENT_H = 3'd3;
    localparam logic [2:0] REG_STEP_PX  = 3'd4;
    localparam logic [2:0] REG_ZOOM_FAC = 3'd5;
    localparam logic [2:0] REG_SCALE_MIN = 3'd6;
    localparam logic [2:0] REG_SCALE_MAX = 3'd7;

    typedef struct packed {
        logic        start;
        logic [27:0] num;
        logic [15:0] den;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIV_BITS-1:0] quot;
    } div_rsp_t;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767)
            r = 16'sh7fff;
        else if (v < -32'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic [13:0] sat14(input logic [DIV_BITS-1:0] v);
        logic [13:0] r;
        if (v > {{(DIV_BITS-14){1'b0}}, SIDE_MAX})
            r = SIDE_MAX;
        else
            r = v[13:0];
        return r;
    endfunction

    // centre an oversize frame, otherwise clamp the coordinate into the screen
    function automatic logic signed [15:0] normalise(input logic signed [15:0] c,
                                                     input logic [13:0] frame,
                                                     input logic [13:0] scr);
        logic [13:0] diff;
        logic signed [15:0] r;
        diff = frame - scr;
        if (frame > scr)
            r = 16'sd0 - $signed({3'b000, diff[13:1]});
        else if (c < 16'sd0)
            r = 16'sd0;
        else if (c > $signed({2'b00, scr - frame}))
            r = $signed({2'b00, scr - frame});
        else
            r = c;
        return r;
    endfunction

    // shift by half the difference of old and new side, truncated toward zero
    function automatic logic signed [15:0] recentre(input logic signed [15:0] p,
                                                    input logic [DIV_BITS-1:0] old_s,
                                                    input logic [DIV_BITS-1:0] new_s);
        logic signed [31:0] diff;
        logic signed [31:0] half;
        diff = $signed({2'b00, old_s}) - $signed({2'b00, new_s});
        half = (diff + $signed({31'd0, diff[31]})) >>> 1;
        return sat16($signed({{16{p[15]}}, p}) + half);
    endfunction

    function automatic logic signed [15:0] place(input logic signed [15:0] wpos,
                                                 input logic [13:0] wside,
                                                 input logic [13:0] fside);
        logic [13:0] diff;
        logic signed [15:0] r;
        diff = fside - wside;
        if (wside >= fside)
            r = wpos;
        else
            r = sat16($signed({{16{wpos[15]}}, wpos}) - $signed({19'd0, diff[13:1]}));
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/viewport_pan_zoom_controller.sv
// Top level: command sequencer, state registers and configuration of the viewport controller.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in        | in_valid/in_ready    | command, win_left/top, win_width/height
//  out     | out       | out_valid/out_ready  | frame_x/y, frame_w/h, cur_scale, tracking_on
//
// Moves, toggle, reset scale and unused codes offer the result beat straight from idle; reset
// position passes through the placing state ST_RPOS. Quotients come from the shared 30-bit divider:
// a refresh needs two (three with the critical scale), a new context likewise, a zoom in four
// (none if refused) and a zoom out five (two or three if refused).
// Reset: all state and configuration registers load their documented defaults at once.
// Stalls: in_ready is low from acceptance until the result beat is taken; cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none
module viewport_pan_zoom_controller (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [3:0]         command,
    input  wire logic signed [15:0] win_left,
    input  wire logic signed [15:0] win_top,
    input  wire logic [13:0]        win_width,
    input  wire logic [13:0]        win_height,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      frame_x,
    output logic signed [15:0]      frame_y,
    output logic [13:0]             frame_w,
    output logic [13:0]             frame_h,
    output logic [15:0]             cur_scale,
    output logic                    tracking_on
);
    import vpz_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE   = 14'b00000000000001,
        ST_START  = 14'b00000000000010,
        ST_DIV    = 14'b00000000000100,
        ST_CMP_A  = 14'b00000000001000,
        ST_CMP_B  = 14'b00000000010000,
        ST_CRIT   = 14'b00000000100000,
        ST_NORM   = 14'b00000001000000,
        ST_RPOS   = 14'b00000010000000,
        ST_ZI_MUL = 14'b00000100000000,
        ST_ZI_RND = 14'b00001000000000,
        ST_ZS_CHK = 14'b00010000000000,
        ST_ZO_CHK = 14'b00100000000000,
        ST_RC     = 14'b01000000000000,
        ST_DONE   = 14'b10000000000000
    } state_t;

    typedef enum logic [2:0] {
        J_PW, J_PH, J_NS, J_NW, J_NH, J_CRIT
    } job_t;

    // configuration
    logic [13:0] screen_w_reg, screen_h_reg, client_w_reg, client_h_reg;
    logic [11:0] step_px_reg;
    logic [15:0] zoom_factor_reg, scale_min_reg, scale_max_reg;

    // architectural state
    logic [15:0]        scale_reg;
    logic signed [15:0] pos_x_reg, pos_y_reg;
    logic [13:0]        size_w_reg, size_h_reg;
    logic               track_reg;

    // sequencer and working registers
    state_t              state_reg;
    job_t                job_reg;
    logic [3:0]          cmd_reg;
    logic signed [15:0]  wl_reg, wt_reg;
    logic [13:0]         ww_reg, wh_reg;
    logic [DIV_BITS-1:0] side_a_reg, side_b_reg, new_a_reg, new_b_reg, ns_reg;
    logic [31:0]         mul_reg;
    logic [27:0]         a_reg, crit_num_reg;
    logic [13:0]         crit_den_reg;
    logic                crit_sel_reg;

    div_req_t dreq;
    div_rsp_t drsp;
    logic [15:0] mul_a, mul_b;
    logic        ns_bad;
    logic [13:0] sat_w, sat_h;

    vpz_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);

    // the state registers themselves are the result beat: they hold while it waits
    assign frame_x     = pos_x_reg;
    assign frame_y     = pos_y_reg;
    assign frame_w     = size_w_reg;
    assign frame_h     = size_h_reg;
    assign cur_scale   = scale_reg;
    assign tracking_on = track_reg;

    // divider operands follow the job in hand
    always_comb
    begin
        dreq.start = (state_reg == ST_START);
        dreq.num   = {client_w_reg, 12'd0};
        dreq.den   = scale_reg;
        case (job_reg)
            J_PW:
            begin
                dreq.num = {client_w_reg, 12'd0};
                dreq.den = scale_reg;
            end
            J_PH:
            begin
                dreq.num = {client_h_reg, 12'd0};
                dreq.den = scale_reg;
            end
            J_NS:
            begin
                dreq.num = {scale_reg, 12'd0};
                dreq.den = zoom_factor_reg;
            end
            J_NW:
            begin
                dreq.num = {client_w_reg, 12'd0};
                dreq.den = ns_reg[15:0];
            end
            J_NH:
            begin
                dreq.num = {client_h_reg, 12'd0};
                dreq.den = ns_reg[15:0];
            end
            J_CRIT:
            begin
                dreq.num = crit_num_reg;
                dreq.den = {2'b00, crit_den_reg};
            end
            default:
            begin
                dreq.num = {client_w_reg, 12'd0};
                dreq.den = scale_reg;
            end
        endcase
    end

    // one multiplier, shared by the zoom-in product and the aspect comparison
    always_comb
    begin
        case (state_reg)
            ST_ZI_MUL:
            begin
                mul_a = scale_reg;
                mul_b = zoom_factor_reg;
            end
            ST_CMP_A:
            begin
                mul_a = {2'b00, client_w_reg};
                mul_b = {2'b00, screen_h_reg};
            end
            default:
            begin
                mul_a = {2'b00, client_h_reg};
                mul_b = {2'b00, screen_w_reg};
            end
        endcase
    end

    assign ns_bad = (ns_reg == '0) || (ns_reg > DIV_BITS'(16'hffff)) ||
                    ((cmd_reg == CMD_ZOOM_IN) ? (ns_reg > DIV_BITS'(scale_max_reg))
                                              : (ns_reg < DIV_BITS'(scale_min_reg)));
    assign sat_w = sat14(side_a_reg);
    assign sat_h = sat14(side_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg    <= 14'd1920;
            screen_h_reg    <= 14'd1080;
            client_w_reg    <= 14'd1920;
            client_h_reg    <= 14'd1080;
            step_px_reg     <= 12'd50;
            zoom_factor_reg <= 16'd5120;
            scale_min_reg   <= 16'd4096;
            scale_max_reg   <= 16'd32768;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCREEN_W:  screen_w_reg    <= cfg_data[13:0];
                REG_SCREEN_H:  screen_h_reg    <= cfg_data[13:0];
                REG_CLIENT_W:  client_w_reg    <= cfg_data[13:0];
                REG_CLIENT_H:  client_h_reg    <= cfg_data[13:0];
                REG_STEP_PX:   step_px_reg     <= cfg_data[11:0];
                REG_ZOOM_FAC:  zoom_factor_reg <= cfg_data;
                REG_SCALE_MIN: scale_min_reg   <= cfg_data;
                REG_SCALE_MAX: scale_max_reg   <= cfg_data;
                default:       scale_max_reg   <= scale_max_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            job_reg    <= J_PW;
            scale_reg  <= DESKTOP_SCALE_DEFAULT;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            size_w_reg <= '0;
            size_h_reg <= '0;
            track_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_DONE;
                        case (command)
                            CMD_REFRESH:
                            begin
                                job_reg   <= J_PW;
                                state_reg <= ST_START;
                            end
                            CMD_UP:
                                pos_y_reg <= sat16(32'(pos_y_reg) - $signed({20'd0, step_px_reg}));
                            CMD_DOWN:
                                pos_y_reg <= sat16(32'(pos_y_reg) + $signed({20'd0, step_px_reg}));
                            CMD_LEFT:
                                pos_x_reg <= sat16(32'(pos_x_reg) - $signed({20'd0, step_px_reg}));
                            CMD_RIGHT:
                                pos_x_reg <= sat16(32'(pos_x_reg) + $signed({20'd0, step_px_reg}));
                            CMD_ZOOM_IN:
                                state_reg <= ST_ZI_MUL;
                            CMD_ZOOM_OUT:
                            begin
                                job_reg   <= J_PW;
                                state_reg <= ST_START;
                            end
                            CMD_RST_SCALE:
                                scale_reg <= track_reg ? WINDOW_SCALE_DEFAULT
                                                       : DESKTOP_SCALE_DEFAULT;
                            CMD_RST_POS:
                                state_reg <= ST_RPOS;
                            CMD_TOGGLE:
                                track_reg <= ~track_reg;
                            CMD_NEW:
                            begin
                                // reset the scale first; the refresh divides by it next
                                scale_reg <= track_reg ? WINDOW_SCALE_DEFAULT
                                                       : DESKTOP_SCALE_DEFAULT;
                                job_reg   <= J_PW;
                                state_reg <= ST_START;
                            end
                            default:
                                state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_START:
                    state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (drsp.done)
                    begin
                        case (job_reg)
                            J_PW:
                            begin
                                job_reg   <= J_PH;
                                state_reg <= ST_START;
                            end
                            J_PH:
                            begin
                                if (cmd_reg == CMD_ZOOM_OUT)
                                    state_reg <= ST_ZO_CHK;
                                else if (cmd_reg == CMD_ZOOM_IN)
                                begin
                                    job_reg   <= J_NW;
                                    state_reg <= ST_START;
                                end
                                else if (side_a_reg > DIV_BITS'(screen_w_reg) &&
                                         drsp.quot > DIV_BITS'(screen_h_reg))
                                    state_reg <= ST_CMP_A;
                                else
                                    state_reg <= ST_NORM;
                            end
                            J_NS:
                                state_reg <= ST_ZS_CHK;
                            J_NW:
                            begin
                                job_reg   <= J_NH;
                                state_reg <= ST_START;
                            end
                            J_NH:
                                state_reg <= ST_RC;
                            default:
                                state_reg <= ST_NORM;
                        endcase
                    end
                end
                ST_CMP_A:
                    state_reg <= ST_CMP_B;
                ST_CMP_B:
                    state_reg <= ST_CRIT;
                ST_CRIT:
                begin
                    job_reg   <= J_CRIT;
                    state_reg <= ST_START;
                end
                ST_NORM:
                begin
                    size_w_reg <= sat_w;
                    size_h_reg <= sat_h;
                    pos_x_reg  <= normalise(pos_x_reg, sat_w, screen_w_reg);
                    pos_y_reg  <= normalise(pos_y_reg, sat_h, screen_h_reg);
                    state_reg  <= (cmd_reg == CMD_NEW) ? ST_RPOS : ST_DONE;
                end
                ST_RPOS:
                begin
                    pos_x_reg <= place(wl_reg, ww_reg, size_w_reg);
                    pos_y_reg <= place(wt_reg, wh_reg, size_h_reg);
                    state_reg <= ST_DONE;
                end
                ST_ZI_MUL:
                    state_reg <= ST_ZI_RND;
                ST_ZI_RND:
                    state_reg <= ST_ZS_CHK;
                ST_ZS_CHK:
                begin
                    if (ns_bad)
                        state_reg <= ST_DONE;
                    else
                    begin
                        job_reg   <= (cmd_reg == CMD_ZOOM_IN) ? J_PW : J_NW;
                        state_reg <= ST_START;
                    end
                end
                ST_ZO_CHK:
                begin
                    // zoom out only while the frame is narrower or lower than the screen
                    if (!(side_a_reg < DIV_BITS'(screen_w_reg) ||
                          side_b_reg < DIV_BITS'(screen_h_reg)) ||
                        zoom_factor_reg == 16'd0)
                        state_reg <= ST_DONE;
                    else
                    begin
                        job_reg   <= J_NS;
                        state_reg <= ST_START;
                    end
                end
                ST_RC:
                begin
                    pos_x_reg <= recentre(pos_x_reg, side_a_reg, new_a_reg);
                    pos_y_reg <= recentre(pos_y_reg, side_b_reg, new_b_reg);
                    scale_reg <= ns_reg[15:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_ready)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // working registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            cmd_reg <= command;
            wl_reg  <= win_left;
            wt_reg  <= win_top;
            ww_reg  <= win_width;
            wh_reg  <= win_height;
        end
        if (state_reg == ST_ZI_MUL || state_reg == ST_CMP_A || state_reg == ST_CMP_B)
            mul_reg <= mul_a * mul_b;
        if (state_reg == ST_CMP_B)
            a_reg <= mul_reg[27:0];
        if (state_reg == ST_ZI_RND)
            ns_reg <= DIV_BITS'((mul_reg + 32'd2048) >> 12);
        if (state_reg == ST_CRIT)
        begin
            // limiting axis takes the screen side, the other is rounded from the ratio
            if (a_reg <= mul_reg[27:0])
            begin
                side_a_reg   <= DIV_BITS'(screen_w_reg);
                crit_num_reg <= mul_reg[27:0];
                crit_den_reg <= client_w_reg;
                crit_sel_reg <= 1'b1;
            end
            else
            begin
                side_b_reg   <= DIV_BITS'(screen_h_reg);
                crit_num_reg <= a_reg;
                crit_den_reg <= client_h_reg;
                crit_sel_reg <= 1'b0;
            end
        end
        if (state_reg == ST_DIV && drsp.done)
        begin
            case (job_reg)
                J_PW: side_a_reg <= drsp.quot;
                J_PH: side_b_reg <= drsp.quot;
                J_NS: ns_reg     <= drsp.quot;
                J_NW: new_a_reg  <= drsp.quot;
                J_NH: new_b_reg  <= drsp.quot;
                J_CRIT:
                begin
                    if (crit_sel_reg)
                        side_b_reg <= drsp.quot;
                    else
                        side_a_reg <= drsp.quot;
                end
                default: ns_reg <= ns_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a command was in progress");
    a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cur_scale != 16'd0)
        else $error("scale reached zero");
    a_div_quiet_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !drsp.busy)
        else $error("divider still busy while result offered");
    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |-> !drsp.busy)
        else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire

### hw/rtl/vpz_div.sv
// Shared restoring divider, one quotient bit a cycle, rounding to nearest.
`timescale 1ns / 1ps
`default_nettype none
module vpz_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire vpz_pkg::div_req_t req,
    output vpz_pkg::div_rsp_t      rsp
);
    import vpz_pkg::*;

    logic [DIV_BITS-1:0]  num_reg;
    logic [16:0]          den_reg;
    logic [16:0]          rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 zero_reg;
    logic [17:0]          shifted;
    logic                 ge;

    assign shifted = {rem_reg, num_reg[DIV_BITS-1]};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend 2n+d over divisor 2d gives the rounded quotient
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= {1'b0, req.num, 1'b0} + {{(DIV_BITS-16){1'b0}}, req.den};
            den_reg  <= {req.den, 1'b0};
            rem_reg  <= '0;
            zero_reg <= (req.den == 16'd0);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 17'(shifted - {1'b0, den_reg}) : shifted[16:0];
            num_reg <= {num_reg[DIV_BITS-2:0], ge};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = zero_reg ? '0 : num_reg;

endmodule
`default_nettype wire

### tb/viewport_pan_zoom_controller_test.sv
// Self-checking testbench for the viewport pan and zoom controller.
`timescale 1ns / 1ps
`default_nettype none
module viewport_pan_zoom_controller_test;
    import vpz_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 600;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [13:0]        w;
        logic [13:0]        h;
        logic [15:0]        s;
        logic               t;
    } view_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [3:0] command;
    logic signed [15:0] win_left;
    logic signed [15:0] win_top;
    logic [13:0] win_width;
    logic [13:0] win_height;
    logic out_valid;
    logic out_ready;
    logic signed [15:0] frame_x;
    logic signed [15:0] frame_y;
    logic [13:0] frame_w;
    logic [13:0] frame_h;
    logic [15:0] cur_scale;
    logic tracking_on;

    // Predicted view state and a shadow of the configuration registers
    longint scr_w, scr_h, cli_w, cli_h, step, zfac, smin, smax;
    longint view_scale, view_x, view_y, view_w, view_h;
    bit     view_track;

    view_t pending_views[$];
    int    mismatches;
    bit    no_idle;          // when set, neither side inserts gaps
    int    hold_off;         // one-shot long stall request for the receiver

    viewport_pan_zoom_controller u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .win_left   (win_left),
        .win_top    (win_top),
        .win_width  (win_width),
        .win_height (win_height),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_x    (frame_x),
        .frame_y    (frame_y),
        .frame_w    (frame_w),
        .frame_h    (frame_h),
        .cur_scale  (cur_scale),
        .tracking_on(tracking_on)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ---------------------------------------------------------------
    // Predictor arithmetic
    // ---------------------------------------------------------------

    // round to nearest, ties up; a zero divisor yields zero
    function automatic longint div_near(longint n, longint d);
        if (d == 0)
            return 0;
        return (2 * n + d) / (2 * d);
    endfunction

    function automatic longint side_for(longint client, longint scale);
        return div_near(client << 12, scale);
    endfunction

    function automatic longint clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // centre an oversize frame, otherwise clamp it into the screen
    function automatic longint fit_axis(longint c, longint frame, longint scr);
        longint margin;
        margin = frame - scr;
        if (margin > 0)
            return clip16(-(margin / 2));
        if (c < 0)
            c = 0;
        if (c > scr - frame)
            c = scr - frame;
        return clip16(c);
    endfunction

    function automatic longint place_axis(longint wpos, longint wside, longint fside);
        if (wside >= fside)
            return wpos;
        return clip16(wpos - (fside - wside) / 2);
    endfunction

    function automatic void refresh_frame();
        longint fw, fh;
        fw = side_for(cli_w, view_scale);
        fh = side_for(cli_h, view_scale);
        // frame beyond the screen on both axes: fall back to the critical scale
        if (fw > scr_w && fh > scr_h)
        begin
            if (cli_w * scr_h <= cli_h * scr_w)
            begin
                fw = scr_w;
                fh = div_near(cli_h * scr_w, cli_w);
            end
            else
            begin
                fh = scr_h;
                fw = div_near(cli_w * scr_h, cli_h);
            end
        end
        if (fw > 16383)
            fw = 16383;
        if (fh > 16383)
            fh = 16383;
        view_w = fw;
        view_h = fh;
        view_x = fit_axis(view_x, fw, scr_w);
        view_y = fit_axis(view_y, fh, scr_h);
    endfunction

    function automatic void shift_to_scale(longint ns);
        longint dw, dh;
        dw = side_for(cli_w, view_scale) - side_for(cli_w, ns);
        dh = side_for(cli_h, view_scale) - side_for(cli_h, ns);
        view_x = clip16(view_x + dw / 2);
        view_y = clip16(view_y + dh / 2);
        view_scale = ns;
    endfunction

    function automatic void step_zoom(bit inward);
        longint ns;
        if (inward)
        begin
            ns = (view_scale * zfac + 2048) >> 12;
            if (ns == 0 || ns > 65535 || ns > smax)
                return;
        end
        else
        begin
            if (!(side_for(cli_w, view_scale) < scr_w || side_for(cli_h, view_scale) < scr_h))
                return;
            if (zfac == 0)
                return;
            ns = div_near(view_scale << 12, zfac);
            if (ns == 0 || ns > 65535 || ns < smin)
                return;
        end
        shift_to_scale(ns);
    endfunction

    // advance the predicted state by one command and queue the view it leaves
    function automatic void apply_command(logic [3:0] cmd, logic signed [15:0] wl,
                                          logic signed [15:0] wt, logic [13:0] ww,
                                          logic [13:0] wh);
        view_t v;
        case (cmd)
            CMD_REFRESH:   refresh_frame();
            CMD_UP:        view_y = clip16(view_y - step);
            CMD_DOWN:      view_y = clip16(view_y + step);
            CMD_LEFT:      view_x = clip16(view_x - step);
            CMD_RIGHT:     view_x = clip16(view_x + step);
            CMD_ZOOM_IN:   step_zoom(1'b1);
            CMD_ZOOM_OUT:  step_zoom(1'b0);
            CMD_RST_SCALE: view_scale = view_track ? WINDOW_SCALE_DEFAULT : DESKTOP_SCALE_DEFAULT;
            CMD_RST_POS:
            begin
                view_y = place_axis(wt, ww * 0 + wh, view_h);
                view_x = place_axis(wl, ww, view_w);
            end
            CMD_TOGGLE:    view_track = !view_track;
            CMD_NEW:
            begin
                view_scale = view_track ? WINDOW_SCALE_DEFAULT : DESKTOP_SCALE_DEFAULT;
                refresh_frame();
                view_y = place_axis(wt, wh, view_h);
                view_x = place_axis(wl, ww, view_w);
            end
            default: ;
        endcase
        v.x = view_x[15:0];
        v.y = view_y[15:0];
        v.w = view_w[13:0];
        v.h = view_h[13:0];
        v.s = view_scale[15:0];
        v.t = view_track;
        pending_views.push_back(v);
    endfunction

    // ---------------------------------------------------------------
    // Shared drivers
    // ---------------------------------------------------------------

    // offer one command; returns at the edge it is taken, valid left high
    task automatic send_command(logic [3:0] cmd, logic signed [15:0] wl,
                                logic signed [15:0] wt, logic [13:0] ww, logic [13:0] wh);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        win_left   <= wl;
        win_top    <= wt;
        win_width  <= ww;
        win_height <= wh;
        do
            @(posedge clk);
        while (!in_ready);
        apply_command(cmd, wl, wt, ww, wh);
    endtask

    task automatic send_random(int unused_weight);
        logic [3:0] cmd;
        if ($urandom_range(0, 99) < unused_weight)
            cmd = 4'($urandom_range(11, 15));
        else
            cmd = 4'($urandom_range(0, 10));
        send_command(cmd, 16'($urandom), 16'($urandom), 14'($urandom), 14'($urandom));
    endtask

    // drop valid and wait for every outstanding view beat
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(val);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SCREEN_W:  scr_w = val & 14'h3fff;
            REG_SCREEN_H:  scr_h = val & 14'h3fff;
            REG_CLIENT_W:  cli_w = val & 14'h3fff;
            REG_CLIENT_H:  cli_h = val & 14'h3fff;
            REG_STEP_PX:   step  = val & 12'hfff;
            REG_ZOOM_FAC:  zfac  = val & 16'hffff;
            REG_SCALE_MIN: smin  = val & 16'hffff;
            default:       smax  = val & 16'hffff;
        endcase
    endtask

    // bias towards the ends of a register's range
    function automatic longint pick(longint lo, longint hi);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            2: return $urandom_range(lo, lo + 16);
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    task automatic write_all(longint sw, longint sh, longint cw, longint ch,
                             longint sp, longint zf, longint mn, longint mx);
        write_reg(REG_SCREEN_W, sw);
        write_reg(REG_SCREEN_H, sh);
        write_reg(REG_CLIENT_W, cw);
        write_reg(REG_CLIENT_H, ch);
        write_reg(REG_STEP_PX, sp);
        write_reg(REG_ZOOM_FAC, zf);
        write_reg(REG_SCALE_MIN, mn);
        write_reg(REG_SCALE_MAX, mx);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // every command at the reset configuration, with the reset-position window fields at their ends
    task automatic test_every_command();
        send_command(CMD_REFRESH, 0, 0, 0, 0);
        send_command(CMD_UP, 0, 0, 0, 0);
        send_command(CMD_DOWN, 0, 0, 0, 0);
        send_command(CMD_LEFT, 0, 0, 0, 0);
        send_command(CMD_RIGHT, 0, 0, 0, 0);
        send_command(CMD_ZOOM_IN, 0, 0, 0, 0);
        send_command(CMD_ZOOM_OUT, 0, 0, 0, 0);
        send_command(CMD_RST_POS, -16'sd32768, -16'sd32768, 14'd0, 14'd0);
        send_command(CMD_RST_POS, 16'sd32767, 16'sd32767, 14'h3fff, 14'h3fff);
        send_command(CMD_ZOOM_IN, 0, 0, 0, 0);
        send_command(CMD_RST_SCALE, 0, 0, 0, 0);
        send_command(CMD_TOGGLE, 0, 0, 0, 0);
        send_command(CMD_RST_SCALE, 0, 0, 0, 0);
        send_command(CMD_NEW, 16'sd100, -16'sd5, 14'd20, 14'd3000);
        send_command(4'd11, 16'h5555, 16'haaaa, 14'h2aaa, 14'h1555);
        send_command(4'd15, 0, 0, 0, 0);
        drain();
    endtask

    // large steps to drive the position into both saturation limits
    task automatic test_move_saturation();
        write_reg(REG_STEP_PX, 4095);
        repeat (9) send_command(CMD_RIGHT, 0, 0, 0, 0);
        repeat (9) send_command(CMD_UP, 0, 0, 0, 0);
        drain();
    endtask

    // tiny screen and huge client: frame exceeds screen, critical scale applies
    task automatic test_critical_scale();
        write_all(3, 2, 16383, 9000, 0, 65535, 1, 65535);
        send_command(CMD_REFRESH, 0, 0, 0, 0);
        send_command(CMD_ZOOM_OUT, 0, 0, 0, 0);
        send_command(CMD_ZOOM_IN, 0, 0, 0, 0);
        drain();
        write_all(2, 3, 9000, 16383, 1, 4097, 65535, 1);
        send_command(CMD_NEW, 0, 0, 0, 0);
        send_command(CMD_ZOOM_IN, 0, 0, 0, 0);
        send_command(CMD_ZOOM_OUT, 0, 0, 0, 0);
        drain();
    endtask

    // random configurations and command streams, several phases
    task automatic test_random_phases(int phases, int per_phase);
        for (int p = 0; p < phases; p++)
        begin
            write_all(pick(1, 16383), pick(1, 16383), pick(1, 16383), pick(1, 16383),
                      pick(0, 4095), pick(4097, 65535), pick(1, 65535), pick(1, 65535));
            no_idle = (p % 4 == 3);
            for (int i = 0; i < per_phase; i++)
                send_random(4);
            drain();
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while commands keep coming; input must stall
    task automatic test_backpressure();
        hold_off = HOLD_OFF_CYCLES;
        for (int i = 0; i < 20; i++)
            send_random(0);
        drain();
    endtask

    // ---------------------------------------------------------------
    // Receiver and checker
    // ---------------------------------------------------------------
    initial
    begin
        int stall;
        view_t exp_v;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 16);
            if (hold_off > 0)
            begin
                stall = hold_off;
                hold_off = 0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_views.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("view beat with nothing expected: x=%0d y=%0d", frame_x, frame_y);
            end
            else
            begin
                exp_v = pending_views.pop_front();
                if (frame_x !== exp_v.x || frame_y !== exp_v.y || frame_w !== exp_v.w ||
                    frame_h !== exp_v.h || cur_scale !== exp_v.s || tracking_on !== exp_v.t)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("view mismatch: exp x=%0d y=%0d w=%0d h=%0d s=%0d t=%0d, got x=%0d y=%0d w=%0d h=%0d s=%0d t=%0d",
                                 exp_v.x, exp_v.y, exp_v.w, exp_v.h, exp_v.s, exp_v.t,
                                 frame_x, frame_y, frame_w, frame_h, cur_scale, tracking_on);
                end
            end
        end
    end

    // watchdog: cycles without any beat on any channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
                || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_SCREEN_W;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        command    <= CMD_REFRESH;
        win_left   <= '0;
        win_top    <= '0;
        win_width  <= '0;
        win_height <= '0;
        mismatches = 0;
        no_idle    = 1'b0;
        hold_off   = 0;
        scr_w = 1920; scr_h = 1080; cli_w = 1920; cli_h = 1080;
        step = 50; zfac = 5120; smin = 4096; smax = 32768;
        view_scale = DESKTOP_SCALE_DEFAULT;
        view_x = 0; view_y = 0; view_w = 0; view_h = 0; view_track = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_every_command();
        test_move_saturation();
        test_critical_scale();
        test_backpressure();
        test_random_phases(9, 145);
        // end on the reset values of the scale limits too
        write_all(1920, 1080, 1920, 1080, 50, 5120, 4096, 32768);
        for (int i = 0; i < 40; i++)
            send_random(2);
        drain();
        repeat (20) @(posedge clk);

        if (mismatches == 0 && pending_views.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
hw/rtl/vpz_pkg.sv
hw/rtl/vpz_div.sv
hw/rtl/viewport_pan_zoom_controller.sv
tb/viewport_pan_zoom_controller_test.sv
